/* hw/rtl/tsg_pkg.sv */
// Package with the request codes and fixed widths of the trapezoid step generator.
`default_nettype none

package tsg_pkg;

   typedef enum logic [2:0] {
      REQ_TICK    = 3'd0,
      REQ_CONFIG  = 3'd1,
      REQ_START   = 3'd2,
      REQ_ENABLE  = 3'd3,
      REQ_DISABLE = 3'd4
   } req_code_type;

   localparam int VelShift     = 10;
   localparam int ReqDataWidth = 80;
   localparam int RspDataWidth = 24;

   typedef struct packed {
      logic [7:0]  accel_rate;
      logic [15:0] peak_velocity;
      logic [15:0] start_velocity;
      logic [15:0] major_steps;
      logic [15:0] minor_steps;
      logic        dir_forward;
   } req_fields_type;

   typedef struct packed {
      logic [15:0] steps_left;
      logic        driver_on;
      logic        dir_out;
      logic        step_pulse;
   } rsp_fields_type;

endpackage

`default_nettype wire

/* hw/rtl/trapezoid_step_generator_top.sv */
// Top level of the trapezoid step generator with a Bresenham minor axis.
//
//   Channel   Direction  Handshake              Payload
//   req_*     in         req_tvalid/req_tready  tuser: req_type; tdata: move fields
//   rsp_*     out        rsp_tvalid/rsp_tready  tdata: step, direction, driver, steps
//
// One item is accepted every cycle unless a stalled result holds the input register; its
// result is on rsp_* once the item moves from the input register into the result register.
// The whole state update for an item is one pass of adds and compares between them.
// Reset is synchronous and clears the motion state, the direction and the driver.
// A stalled result holds the result register and, behind it, the input register.
`default_nettype none

module trapezoid_step_generator_top
   import tsg_pkg::*;
#(
   parameter int PHASE_FRAC_BITS = 20
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // tdata from bit 0: dir_forward, minor_steps, major_steps, start_velocity,
   // peak_velocity, accel_rate, zero fill.
   input  wire logic [ReqDataWidth-1:0] req_tdata,
   // tuser from bit 0: req_type.
   input  wire logic [2:0]              req_tuser,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // tdata from bit 0: step_pulse, dir_out, driver_on, steps_left, zero fill.
   output logic [RspDataWidth-1:0]      rsp_tdata
);

   localparam logic [31:0] OneStep = 32'd1 << PHASE_FRAC_BITS;

   logic           in_valid_ff;
   logic [2:0]     in_type_ff;
   req_fields_type in_data_ff;
   logic           out_valid_ff;
   rsp_fields_type out_data_ff;
   logic           advance;

   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] half_major_ff, half_major_in;
   logic [15:0] ramp_steps_ff, ramp_steps_in;
   logic        accelerating_ff, accelerating_in;
   logic        decelerating_ff, decelerating_in;
   logic [31:0] velocity_ff, velocity_in;
   logic [31:0] velocity_limit_ff, velocity_limit_in;
   logic [7:0]  accel_value_ff, accel_value_in;
   logic [31:0] phase_ff, phase_in;
   logic [31:0] line_error_ff, line_error_in;
   logic [15:0] axis_steps_ff, axis_steps_in;
   logic [15:0] axis_steps_pending_ff, axis_steps_pending_in;
   logic        dir_pending_ff, dir_pending_in;
   logic        dir_now_ff, dir_now_in;
   logic        enabled_ff, enabled_in;
   logic        pulse;

   logic [31:0] vel_tick;
   logic [31:0] phase_sum;
   logic [31:0] err_sum;
   logic [15:0] remaining_dec;
   logic        take_step;
   logic        err_over;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - $bits(rsp_fields_type)){1'b0}}, out_data_ff};

   always_comb begin
      vel_tick = velocity_ff;
      if (accelerating_ff) begin
         vel_tick = velocity_ff + {24'd0, accel_value_ff};
      end else if (decelerating_ff) begin
         vel_tick = (velocity_ff > {24'd0, accel_value_ff})
                    ? velocity_ff - {24'd0, accel_value_ff} : 32'd0;
      end
      phase_sum     = phase_ff + vel_tick;
      take_step     = phase_sum > OneStep;
      err_sum       = line_error_ff + {16'd0, axis_steps_ff};
      err_over      = !err_sum[31] && (err_sum > {16'd0, half_major_ff});
      remaining_dec = remaining_ff - 16'd1;
   end

   always_comb begin
      remaining_in          = remaining_ff;
      half_major_in         = half_major_ff;
      ramp_steps_in         = ramp_steps_ff;
      accelerating_in       = accelerating_ff;
      decelerating_in       = decelerating_ff;
      velocity_in           = velocity_ff;
      velocity_limit_in     = velocity_limit_ff;
      accel_value_in        = accel_value_ff;
      phase_in              = phase_ff;
      line_error_in         = line_error_ff;
      axis_steps_in         = axis_steps_ff;
      axis_steps_pending_in = axis_steps_pending_ff;
      dir_pending_in        = dir_pending_ff;
      dir_now_in            = dir_now_ff;
      enabled_in            = enabled_ff;
      pulse                 = 1'b0;

      unique case (in_type_ff)
         REQ_TICK: begin
            if (remaining_ff != 16'd0) begin
               velocity_in = vel_tick;
               if (!accelerating_ff && !decelerating_ff && remaining_ff <= ramp_steps_ff) begin
                  decelerating_in = 1'b1;
               end
               phase_in = phase_sum;
               if (take_step) begin
                  pulse         = err_over;
                  line_error_in = err_over ? err_sum - {15'd0, half_major_ff, 1'b0} : err_sum;
                  remaining_in  = remaining_dec;
                  if (accelerating_ff) begin
                     ramp_steps_in = ramp_steps_ff + 16'd1;
                     if (remaining_dec == half_major_ff) begin
                        accelerating_in = 1'b0;
                        decelerating_in = 1'b1;
                     end
                  end
                  phase_in = phase_sum - OneStep;
               end
               if (vel_tick >= velocity_limit_ff) begin
                  accelerating_in = 1'b0;
               end
            end
         end
         REQ_CONFIG: begin
            dir_pending_in        = in_data_ff.dir_forward;
            axis_steps_pending_in = in_data_ff.minor_steps;
         end
         REQ_START: begin
            enabled_in        = 1'b1;
            velocity_in       = {6'd0, in_data_ff.start_velocity, {VelShift{1'b0}}};
            velocity_limit_in = {6'd0, in_data_ff.peak_velocity, {VelShift{1'b0}}};
            accel_value_in    = in_data_ff.accel_rate;
            phase_in          = 32'd0;
            accelerating_in   = 1'b1;
            decelerating_in   = 1'b0;
            ramp_steps_in     = 16'd0;
            line_error_in     = 32'd0;
            axis_steps_in     = axis_steps_pending_ff;
            dir_now_in        = dir_pending_ff;
            remaining_in      = in_data_ff.major_steps;
            half_major_in     = {1'b0, in_data_ff.major_steps[15:1]};
         end
         REQ_ENABLE: begin
            enabled_in = 1'b1;
         end
         REQ_DISABLE: begin
            enabled_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
         remaining_ff          <= 16'd0;
         half_major_ff         <= 16'd0;
         ramp_steps_ff         <= 16'd0;
         accelerating_ff       <= 1'b0;
         decelerating_ff       <= 1'b0;
         velocity_ff           <= 32'd0;
         velocity_limit_ff     <= 32'd0;
         accel_value_ff        <= 8'd0;
         phase_ff              <= 32'd0;
         line_error_ff         <= 32'd0;
         axis_steps_ff         <= 16'd0;
         axis_steps_pending_ff <= 16'd0;
         dir_pending_ff        <= 1'b0;
         dir_now_ff            <= 1'b0;
         enabled_ff            <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
            in_type_ff  <= req_tuser;
            in_data_ff  <= req_tdata[$bits(req_fields_type)-1:0];
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
            if (in_valid_ff) begin
               out_data_ff.step_pulse <= pulse;
               out_data_ff.dir_out    <= dir_now_in;
               out_data_ff.driver_on  <= enabled_in;
               out_data_ff.steps_left <= remaining_in;
               remaining_ff           <= remaining_in;
               half_major_ff          <= half_major_in;
               ramp_steps_ff          <= ramp_steps_in;
               accelerating_ff        <= accelerating_in;
               decelerating_ff        <= decelerating_in;
               velocity_ff            <= velocity_in;
               velocity_limit_ff      <= velocity_limit_in;
               accel_value_ff         <= accel_value_in;
               phase_ff               <= phase_in;
               line_error_ff          <= line_error_in;
               axis_steps_ff          <= axis_steps_in;
               axis_steps_pending_ff  <= axis_steps_pending_in;
               dir_pending_ff         <= dir_pending_in;
               dir_now_ff             <= dir_now_in;
               enabled_ff             <= enabled_in;
            end
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !(accelerating_ff && decelerating_ff))
      else $error("Ramp is accelerating and decelerating at once.");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance && (in_type_ff != REQ_TICK || remaining_ff == 16'd0))
      |=> !out_data_ff.step_pulse)
      else $error("Step pulse from an item that cannot take a step.");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance && in_type_ff == REQ_TICK)
      |=> (remaining_ff == $past(remaining_ff) || remaining_ff == $past(remaining_ff) - 16'd1))
      else $error("A tick took more than one major step.");

endmodule

`default_nettype wire
